// ===== hw/rtl/gbq_pkg.sv =====
// Shared types and constants for the grabber engage qualifier.
// Holds register indexes, the item opcode and the register reset values.
// No dependencies.
package gbq_pkg;

   localparam int unsigned REG_W     = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned RSP_W     = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENGAGE_HIGH   = 2'd0,
      CSR_ENGAGE_LOW    = 2'd1,
      CSR_RELEASE_TICKS = 2'd2,
      CSR_TOUCH_RISE    = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   localparam logic [REG_W-1:0] ENGAGE_HIGH_RST   = 16'd600;
   localparam logic [REG_W-1:0] ENGAGE_LOW_RST    = 16'd400;
   localparam logic [REG_W-1:0] RELEASE_TICKS_RST = 16'd20;
   localparam logic [REG_W-1:0] TOUCH_RISE_RST    = 16'd50;
   localparam logic [REG_W-1:0] COUNT_MAX         = 16'hFFFF;

   typedef struct packed {
      logic engaged;
      logic ball_out;
      logic left_touched;
      logic right_touched;
   } flags_type;

endpackage

// ===== hw/rtl/grabber_engage_qualifier.sv =====
// Grabber engage qualifier: hysteresis on two arm sensors, release timer, touch flags.
// Input register, then result register; throughput 1 beat per cycle when not stalled.
// A result beat waiting on rsp_tready does not stop the input register from taking
// a beat; the pair of registers stalls only when both are full and the result is held.
// Synchronous active-high reset: flags clear, ball_out sets, timer and last readings
// clear, registers load their defaults. Depends on gbq_pkg.
module grabber_engage_qualifier #(
   parameter int unsigned SENSOR_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: left_arm [SENSOR_BITS-1:0], right_arm above it, zero pad to bytes
   input  logic [((2*SENSOR_BITS+7)/8)*8-1:0]     req_tdata,
   // tuser: opcode (0 arm sample, 1 time tick)
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: engaged, ball_out, left_touched, right_touched, zero pad
   output logic [gbq_pkg::RSP_W-1:0]              rsp_tdata,
   input  logic                                   csr_we,
   input  logic [gbq_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gbq_pkg::REG_W-1:0]              csr_wdata
);

   localparam int unsigned CMP_W =
      (SENSOR_BITS > gbq_pkg::REG_W) ? SENSOR_BITS : gbq_pkg::REG_W;

   // configuration registers
   logic [gbq_pkg::REG_W-1:0] engage_high_ff, engage_low_ff;
   logic [gbq_pkg::REG_W-1:0] release_ticks_ff, touch_rise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         engage_high_ff   <= gbq_pkg::ENGAGE_HIGH_RST;
         engage_low_ff    <= gbq_pkg::ENGAGE_LOW_RST;
         release_ticks_ff <= gbq_pkg::RELEASE_TICKS_RST;
         touch_rise_ff    <= gbq_pkg::TOUCH_RISE_RST;
      end else if (csr_we) begin
         unique case (gbq_pkg::csr_index_type'(csr_index))
            gbq_pkg::CSR_ENGAGE_HIGH:   engage_high_ff   <= csr_wdata;
            gbq_pkg::CSR_ENGAGE_LOW:    engage_low_ff    <= csr_wdata;
            gbq_pkg::CSR_RELEASE_TICKS: release_ticks_ff <= csr_wdata;
            gbq_pkg::CSR_TOUCH_RISE:    touch_rise_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic                   s1_valid_ff;
   logic                   s1_tick_ff;
   logic [SENSOR_BITS-1:0] s1_left_ff, s1_right_ff;
   logic                   s1_adv;
   logic                   req_take;

   // result register
   logic                rsp_valid_ff;
   gbq_pkg::flags_type  rsp_flags_ff, rsp_flags_in;

   // qualifier state
   logic                      engaged_ff, engaged_in;
   logic                      ball_out_ff, ball_out_in;
   logic [gbq_pkg::REG_W-1:0] release_count_ff, release_count_in;
   logic [SENSOR_BITS-1:0]    left_last_ff, right_last_ff;
   logic                      left_touch_ff, left_touch_in;
   logic                      right_touch_ff, right_touch_in;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_tick_ff  <= req_tuser;
         s1_left_ff  <= req_tdata[SENSOR_BITS-1:0];
         s1_right_ff <= req_tdata[2*SENSOR_BITS-1:SENSOR_BITS];
      end
   end

   // compares against the registers, widened to a common width
   logic [CMP_W-1:0]     left_c, right_c, high_c, low_c, rise_lim_c;
   logic [SENSOR_BITS:0] left_rise, right_rise;
   logic                 both_high, both_low;

   always_comb begin
      left_c     = CMP_W'(s1_left_ff);
      right_c    = CMP_W'(s1_right_ff);
      high_c     = CMP_W'(engage_high_ff);
      low_c      = CMP_W'(engage_low_ff);
      rise_lim_c = CMP_W'(touch_rise_ff);
      both_high  = (left_c > high_c) && (right_c > high_c);
      both_low   = (left_c < low_c) && (right_c < low_c);
      // sign bit set means the arm fell: never a touch
      left_rise  = {1'b0, s1_left_ff} - {1'b0, left_last_ff};
      right_rise = {1'b0, s1_right_ff} - {1'b0, right_last_ff};

      engaged_in       = engaged_ff;
      ball_out_in      = ball_out_ff;
      release_count_in = release_count_ff;
      left_touch_in    = left_touch_ff;
      right_touch_in   = right_touch_ff;

      unique case (gbq_pkg::opcode_type'(s1_tick_ff))
         gbq_pkg::OP_TICK: begin
            if (release_count_ff != gbq_pkg::COUNT_MAX) begin
               release_count_in = release_count_ff + 1'b1;
            end
         end
         gbq_pkg::OP_SAMPLE: begin
            if (!engaged_ff) begin
               if (both_high) begin
                  engaged_in  = 1'b1;
                  ball_out_in = 1'b0;
               end
            end else if (both_low) begin
               // restart sample zeroes the timer, so it cannot drop engagement
               if (!ball_out_ff) begin
                  ball_out_in      = 1'b1;
                  release_count_in = '0;
               end else if (release_count_ff > release_ticks_ff) begin
                  engaged_in = 1'b0;
               end
            end
            left_touch_in  = !left_rise[SENSOR_BITS] &&
                             (CMP_W'(left_rise[SENSOR_BITS-1:0]) > rise_lim_c);
            right_touch_in = !right_rise[SENSOR_BITS] &&
                             (CMP_W'(right_rise[SENSOR_BITS-1:0]) > rise_lim_c);
         end
         default: ;
      endcase

      rsp_flags_in.engaged       = engaged_in;
      rsp_flags_in.ball_out      = ball_out_in;
      rsp_flags_in.left_touched  = left_touch_in;
      rsp_flags_in.right_touched = right_touch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         engaged_ff       <= 1'b0;
         ball_out_ff      <= 1'b1;
         release_count_ff <= '0;
         left_last_ff     <= '0;
         right_last_ff    <= '0;
         left_touch_ff    <= 1'b0;
         right_touch_ff   <= 1'b0;
      end else if (s1_adv) begin
         engaged_ff       <= engaged_in;
         ball_out_ff      <= ball_out_in;
         release_count_ff <= release_count_in;
         left_touch_ff    <= left_touch_in;
         right_touch_ff   <= right_touch_in;
         if (!s1_tick_ff) begin
            left_last_ff  <= s1_left_ff;
            right_last_ff <= s1_right_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(gbq_pkg::RSP_W-4){1'b0}},
                        rsp_flags_ff.right_touched, rsp_flags_ff.left_touched,
                        rsp_flags_ff.ball_out, rsp_flags_ff.engaged};

   // engaging always clears ball_out
   a_engage_clears_ball: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $rose(engaged_ff) |-> !ball_out_ff)
      else $error("engaged rose with ball_out still set");

   // engagement drops only after the release has started
   a_drop_needs_release: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $fell(engaged_ff) |-> $past(ball_out_ff))
      else $error("engaged dropped without ball_out");

   // the timer saturates on ticks
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_tick_ff && (release_count_ff == gbq_pkg::COUNT_MAX)
      |=> release_count_ff == gbq_pkg::COUNT_MAX)
      else $error("release timer wrapped");

   // a beat never moves into a full input register that is not draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input register overrun");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for grabber_engage_qualifier: arm samples and timer ticks in,
// one flag beat out per item, checked against an in-bench model of the qualifier.
// Depends on gbq_pkg and the grabber_engage_qualifier RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int ARM_W        = 16;
   localparam int STALL_LIMIT  = 3000;
   localparam int SHOW_LIMIT   = 10;
   localparam int TIMER_LIMIT  = 4;

   typedef struct packed {
      gbq_pkg::opcode_type op;
      logic [ARM_W-1:0]    left;
      logic [ARM_W-1:0]    right;
   } arm_beat_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [gbq_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we     = 1'b0;
   logic [gbq_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [gbq_pkg::REG_W-1:0]     csr_wdata  = '0;

   grabber_engage_qualifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Bench copy of the registers and of the qualifier state
   logic [gbq_pkg::REG_W-1:0] cfg_high, cfg_low, cfg_release, cfg_touch;
   logic                      engaged_q, ball_out_q, left_touch_q, right_touch_q;
   logic [gbq_pkg::REG_W-1:0] release_timer;
   logic [ARM_W-1:0]          left_prev, right_prev;

   arm_beat_type        beats_to_send[$];
   gbq_pkg::flags_type  flags_due[$];
   arm_beat_type        beat_on_bus;

   bit calm       = 1'b0;
   int req_gap    = 0;
   int rsp_gap    = 0;
   int idle_count = 0;
   int mismatches = 0;
   int checked    = 0;
   int samples    = 0;
   int ticks      = 0;
   int engages    = 0;
   int drops      = 0;
   int configs    = 0;
   int queued     = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advance the qualifier state by one beat and return the flags it shows
   function automatic gbq_pkg::flags_type qualify_beat(arm_beat_type b);
      gbq_pkg::flags_type f;
      if (b.op == gbq_pkg::OP_TICK) begin
         ticks++;
         if (release_timer != gbq_pkg::COUNT_MAX)
            release_timer = release_timer + 1'b1;
      end else begin
         samples++;
         if (!engaged_q) begin
            if (b.left > cfg_high && b.right > cfg_high) begin
               engaged_q  = 1'b1;
               ball_out_q = 1'b0;
               engages++;
            end
         end else if (b.left < cfg_low && b.right < cfg_low) begin
            if (!ball_out_q) begin
               ball_out_q    = 1'b1;
               release_timer = '0;
            end
            if (release_timer > cfg_release) begin
               engaged_q = 1'b0;
               drops++;
            end
         end
         // signed rise: a falling arm never counts
         left_touch_q  = (int'(b.left) - int'(left_prev)) > int'(cfg_touch);
         right_touch_q = (int'(b.right) - int'(right_prev)) > int'(cfg_touch);
         left_prev  = b.left;
         right_prev = b.right;
      end
      f.engaged       = engaged_q;
      f.ball_out      = ball_out_q;
      f.left_touched  = left_touch_q;
      f.right_touched = right_touch_q;
      return f;
   endfunction

   // Driver: present queued beats, with random gap bursts unless calm
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            flags_due.push_back(qualify_beat(beat_on_bus));
         if (!req_tvalid || req_tready) begin
            if (!calm && req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!calm && beats_to_send.size() != 0 &&
                         $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 12) - 1;
               req_tvalid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
               beat_on_bus = beats_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {beat_on_bus.right, beat_on_bus.left};
               req_tuser  <= beat_on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (flags_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("%0t: result beat with nothing expected, data %h", $realtime,
                           rsp_tdata);
            end else begin
               gbq_pkg::flags_type want;
               want = flags_due.pop_front();
               if (rsp_tdata[0] !== want.engaged || rsp_tdata[1] !== want.ball_out ||
                   rsp_tdata[2] !== want.left_touched ||
                   rsp_tdata[3] !== want.right_touched) begin
                  mismatches++;
                  if (mismatches <= SHOW_LIMIT)
                     $display({"%0t: flags mismatch: engaged %b/%b ball_out %b/%b ",
                               "left %b/%b right %b/%b (exp/got)"},
                              $realtime, want.engaged, rsp_tdata[0],
                              want.ball_out, rsp_tdata[1],
                              want.left_touched, rsp_tdata[2],
                              want.right_touched, rsp_tdata[3]);
               end
            end
         end
         if (!calm && rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding", idle_count,
                  flags_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_beat(input gbq_pkg::opcode_type op, input logic [ARM_W-1:0] l,
                            input logic [ARM_W-1:0] r);
      arm_beat_type b;
      b.op    = op;
      b.left  = l;
      b.right = r;
      beats_to_send.push_back(b);
      queued++;
   endtask

   // Hold until everything sent has come back, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || req_tvalid || flags_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_config(input logic [gbq_pkg::REG_W-1:0] h,
                               input logic [gbq_pkg::REG_W-1:0] l,
                               input logic [gbq_pkg::REG_W-1:0] rt,
                               input logic [gbq_pkg::REG_W-1:0] tr);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= gbq_pkg::CSR_ENGAGE_HIGH;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= gbq_pkg::CSR_ENGAGE_LOW;
      csr_wdata <= l;
      @(posedge clock);
      csr_index <= gbq_pkg::CSR_RELEASE_TICKS;
      csr_wdata <= rt;
      @(posedge clock);
      csr_index <= gbq_pkg::CSR_TOUCH_RISE;
      csr_wdata <= tr;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_high    = h;
      cfg_low     = l;
      cfg_release = rt;
      cfg_touch   = tr;
      configs++;
      @(negedge clock);
   endtask

   function automatic logic [ARM_W-1:0] arm_above();
      int top;
      if (cfg_high == 16'hFFFF)
         return 16'hFFFF;
      top = int'(cfg_high) + 400;
      if (top > 65535)
         top = 65535;
      return ARM_W'($urandom_range(int'(cfg_high) + 1, top));
   endfunction

   function automatic logic [ARM_W-1:0] arm_below();
      int bottom;
      if (cfg_low == 0)
         return '0;
      bottom = int'(cfg_low) - 400;
      if (bottom < 0)
         bottom = 0;
      return ARM_W'($urandom_range(bottom, int'(cfg_low) - 1));
   endfunction

   function automatic logic [ARM_W-1:0] arm_any();
      case ($urandom_range(0, 2))
         0: return arm_above();
         1: return arm_below();
         default: return ARM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly full engage / release / timeout cycles, some raw noise
   task automatic fill_random(input int count);
      int stop_at;
      int tick_cap;
      stop_at = queued + count;
      while (queued < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            push_beat(gbq_pkg::opcode_type'($urandom_range(0, 1)),
                      ARM_W'($urandom_range(0, 65535)), ARM_W'($urandom_range(0, 65535)));
         end else begin
            repeat ($urandom_range(1, 3))
               push_beat(gbq_pkg::OP_SAMPLE, arm_above(), arm_above());
            repeat ($urandom_range(0, 3))
               push_beat(gbq_pkg::OP_SAMPLE, arm_any(), arm_any());
            repeat ($urandom_range(1, 2))
               push_beat(gbq_pkg::OP_SAMPLE, arm_below(), arm_below());
            tick_cap = (int'(cfg_release) + 3 > 40) ? 40 : int'(cfg_release) + 3;
            repeat ($urandom_range(0, tick_cap)) begin
               if ($urandom_range(0, 5) == 0)
                  push_beat(gbq_pkg::OP_SAMPLE, arm_below(), arm_below());
               push_beat(gbq_pkg::OP_TICK, ARM_W'($urandom_range(0, 65535)),
                         ARM_W'($urandom_range(0, 65535)));
            end
            repeat ($urandom_range(1, 2))
               push_beat(gbq_pkg::OP_SAMPLE, arm_below(), arm_below());
         end
      end
   endtask

   initial begin
      logic [gbq_pkg::REG_W-1:0] h;
      cfg_high      = gbq_pkg::ENGAGE_HIGH_RST;
      cfg_low       = gbq_pkg::ENGAGE_LOW_RST;
      cfg_release   = gbq_pkg::RELEASE_TICKS_RST;
      cfg_touch     = gbq_pkg::TOUCH_RISE_RST;
      engaged_q     = 1'b0;
      ball_out_q    = 1'b1;
      left_touch_q  = 1'b0;
      right_touch_q = 1'b0;
      release_timer = '0;
      left_prev     = '0;
      right_prev    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: strict engage compare, partial release, restart, touch
      push_beat(gbq_pkg::OP_SAMPLE, 16'd600, 16'd601);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd601, 16'd601);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd399, 16'd400);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd399, 16'd399);
      repeat (3) push_beat(gbq_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd650, 16'd700);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd0, 16'd0);

      // Top thresholds, zero release and zero touch: timer drop after one tick
      write_config(16'hFFFE, 16'hFFFF, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF);
      push_beat(gbq_pkg::OP_SAMPLE, 16'hFFFE, 16'hFFFE);
      push_beat(gbq_pkg::OP_TICK, 16'h0000, 16'h0000);
      push_beat(gbq_pkg::OP_SAMPLE, 16'hFFFE, 16'hFFFE);
      push_beat(gbq_pkg::OP_SAMPLE, 16'hFFFF, 16'h0000);

      // Zero thresholds: release impossible; full-scale rise is not above max touch
      write_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd1, 16'd1);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_SAMPLE, 16'hFFFF, 16'hFFFF);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_TICK, 16'd0, 16'd0);

      // Timer at the limit holds engagement, one tick past it drops
      write_config(16'd100, 16'd200, REG_LIMIT(), 16'd50);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd150, 16'd150);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd150, 16'd150);
      repeat (TIMER_LIMIT) push_beat(gbq_pkg::OP_TICK, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd150, 16'd150);
      push_beat(gbq_pkg::OP_TICK, 16'd0, 16'd0);
      push_beat(gbq_pkg::OP_SAMPLE, 16'd150, 16'd150);

      // Random phases under a spread of settings; the last one runs without gaps
      for (int p = 0; p < 5; p++) begin
         if (p == 2) begin
            write_config(gbq_pkg::REG_W'($urandom_range(0, 65535)),
                         gbq_pkg::REG_W'($urandom_range(0, 65535)),
                         gbq_pkg::REG_W'($urandom_range(0, 65535)),
                         gbq_pkg::REG_W'($urandom_range(0, 65535)));
         end else begin
            h = gbq_pkg::REG_W'($urandom_range(300, 4000));
            write_config(h, gbq_pkg::REG_W'($urandom_range(0, int'(h) + 200)),
                         gbq_pkg::REG_W'($urandom_range(0, 25)),
                         gbq_pkg::REG_W'($urandom_range(0, 300)));
         end
         calm = (p == 4);
         fill_random(95);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d samples and %0d ticks under %0d settings; %0d results checked",
               samples, ticks, configs + 1, checked);
      $display("model saw %0d engagements and %0d timed releases; %0d mismatches",
               engages, drops, mismatches);
      if (mismatches == 0 && flags_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   function automatic logic [gbq_pkg::REG_W-1:0] REG_LIMIT();
      return gbq_pkg::REG_W'(TIMER_LIMIT);
   endfunction

endmodule

// ===== files.f =====
hw/rtl/gbq_pkg.sv
hw/rtl/grabber_engage_qualifier.sv
sim/tb_top.sv
